FILE: sv/rgbrle_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder package
// Shared types and constants for the decoder core and its submodules.
// ----------------------------------------------------------------------------
package rgbrle_pkg;

	// rectangle limits; larger requests saturate to these
	localparam int MaxWidth  = 320;
	localparam int MaxHeight = 240;

	// state widths
	localparam int CountW = 18;
	localparam int BlockW = 9;

	// command codes carried in the input tuser
	localparam logic CmdBegin = 1'b0;
	localparam logic CmdData  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [8:0] rect_width;
		logic [7:0] rect_height;
		logic       rle_enable;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic [7:0]  run_count;
		logic        rejected;
		logic [7:0]  rejected_byte;
	} result_t;

	// handshake between the decoder and the output register
	typedef struct packed {
		logic advance;
		logic has_result;
	} step_t;

endpackage

FILE: sv/rgb565_rle_block_decoder_core.sv
// ----------------------------------------------------------------------------
// RGB565 run-length block decoder core
// Decodes raw or run-length RGB565 byte streams into color runs.
// ----------------------------------------------------------------------------
// A result shows on m_axis once its input has passed the input register, then the
// result register.
// Throughput: one item per cycle. An item that yields a result waits in the
// input register while the previous result is stalled, which holds off s_axis;
// items that yield no result keep flowing.
// Reset (arst_n low) empties both registers and clears the frame state.
// ----------------------------------------------------------------------------
module rgb565_rle_block_decoder_core import rgbrle_pkg::*; #(
	parameter int MAX_WIDTH  = MaxWidth,
	parameter int MAX_HEIGHT = MaxHeight
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // rect_width, rect_height, rle_enable, data_byte
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // pixel_color, run_count, rejected_byte
	output logic        m_axis_tuser   // rejected
);

	logic    valid_s1;
	item_t   item_s1;
	result_t result;
	logic    has_result;
	step_t   step;

	// advance the input stage unless its result has nowhere to go
	assign step.has_result = has_result;
	assign step.advance    = valid_s1 &&
		(!has_result || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready   = !valid_s1 || step.advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd         <= s_axis_tuser;
			item_s1.rect_width  <= s_axis_tdata[8:0];
			item_s1.rect_height <= s_axis_tdata[16:9];
			item_s1.rle_enable  <= s_axis_tdata[17];
			item_s1.data_byte   <= s_axis_tdata[25:18];
		end
	end

	rgbrle_dec #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.advance    (step.advance),
		.has_result (has_result),
		.result     (result)
	);

	rgbrle_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.result        (result),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: sv/rgbrle_dec.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder: frame and block state
// Holds the frame, block and pairing state and decodes one item per cycle while the input stage advances.
// ----------------------------------------------------------------------------
module rgbrle_dec import rgbrle_pkg::*; #(
	parameter int MAX_WIDTH  = MaxWidth,
	parameter int MAX_HEIGHT = MaxHeight
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    advance,
	output logic    has_result,
	output result_t result
);

	logic [CountW-1:0] byte_count_q, byte_count_n, byte_inc;
	logic [CountW-1:0] frame_bytes_q, frame_bytes_n;
	logic              mode_rle_q, mode_rle_n;
	logic [BlockW-1:0] block_len_q, block_len_n, hdr_len;
	logic [BlockW-1:0] block_pos_q, block_pos_n, pos_inc;
	logic              block_common_q, block_common_n;
	logic [7:0]        low_byte_q, low_byte_n;
	logic [8:0]        w_sat;
	logic [7:0]        h_sat;
	logic [16:0]       area;
	logic              do_pair;

	// saturate the rectangle and size the frame
	always_comb begin
		w_sat = item.rect_width;
		h_sat = item.rect_height;
		if (32'(item.rect_width) > MAX_WIDTH) begin
			w_sat = 9'(MAX_WIDTH);
		end
		if (32'(item.rect_height) > MAX_HEIGHT) begin
			h_sat = 8'(MAX_HEIGHT);
		end
		area = 17'(w_sat) * 17'(h_sat);
	end

	assign byte_inc = byte_count_q + CountW'(1);
	assign pos_inc  = block_pos_q + BlockW'(1);
	assign hdr_len  = {8'({1'b0, item.data_byte[6:0]} + 8'd1), 1'b0};

	// decode one item against the current state
	always_comb begin
		byte_count_n   = byte_count_q;
		frame_bytes_n  = frame_bytes_q;
		mode_rle_n     = mode_rle_q;
		block_len_n    = block_len_q;
		block_pos_n    = block_pos_q;
		block_common_n = block_common_q;
		low_byte_n     = low_byte_q;
		has_result     = 1'b0;
		result         = '0;
		do_pair        = 1'b0;

		if (item.cmd == CmdBegin) begin
			frame_bytes_n  = {area, 1'b0};
			byte_count_n   = '0;
			mode_rle_n     = item.rle_enable;
			block_len_n    = '0;
			block_pos_n    = '0;
			block_common_n = 1'b0;
		end else if (byte_count_q >= frame_bytes_q) begin
			has_result           = 1'b1;
			result.rejected      = 1'b1;
			result.rejected_byte = item.data_byte;
		end else if (!mode_rle_q) begin
			do_pair = 1'b1;
		end else if (block_pos_q >= block_len_q) begin
			// block header
			block_len_n    = hdr_len;
			block_common_n = item.data_byte[7];
			block_pos_n    = item.data_byte[7] ? hdr_len - 9'd2 : '0;
		end else begin
			block_pos_n = pos_inc;
			if (block_common_q) begin
				if (pos_inc >= block_len_q) begin
					has_result         = 1'b1;
					result.pixel_color = {item.data_byte, low_byte_q};
					result.run_count   = block_len_q[8:1];
					byte_count_n       = byte_count_q + CountW'(block_len_q);
				end else begin
					low_byte_n = item.data_byte;
				end
			end else begin
				do_pair = 1'b1;
			end
		end

		// pair bytes into a pixel, low byte first
		if (do_pair) begin
			byte_count_n = byte_inc;
			if (byte_inc[0]) begin
				low_byte_n = item.data_byte;
			end else begin
				has_result         = 1'b1;
				result.pixel_color = {item.data_byte, low_byte_q};
				result.run_count   = 8'd1;
			end
		end
	end

	// commit state when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			frame_bytes_q  <= '0;
			mode_rle_q     <= 1'b0;
			block_len_q    <= '0;
			block_pos_q    <= '0;
			block_common_q <= 1'b0;
			low_byte_q     <= '0;
		end else if (advance) begin
			byte_count_q   <= byte_count_n;
			frame_bytes_q  <= frame_bytes_n;
			mode_rle_q     <= mode_rle_n;
			block_len_q    <= block_len_n;
			block_pos_q    <= block_pos_n;
			block_common_q <= block_common_n;
			low_byte_q     <= low_byte_n;
		end
	end

endmodule

FILE: sv/rgbrle_out.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder: result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rgbrle_out import rgbrle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  step_t       step,
	input  result_t     result,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // pixel_color, run_count, rejected_byte
	output logic        m_axis_tuser   // rejected
);

	logic    valid_q;
	result_t res_q;

	// load a new result or drop the one just transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step.advance && step.has_result) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.advance && step.has_result) begin
			res_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.rejected_byte, res_q.run_count, res_q.pixel_color};
	assign m_axis_tuser  = res_q.rejected;

endmodule

FILE: sv/rgbrle_chk.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder checker
// Port-level checks on the result stream, bound to the decoder core.
// ----------------------------------------------------------------------------
module rgbrle_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a rejected byte carries no color and no count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
		else $error("rejected result has color or count");

	// a pixel result hands back no byte and has a nonzero count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tdata[31:24] == 8'd0 && m_axis_tdata[23:16] != 8'd0)
		else $error("pixel result malformed");

	// a run never exceeds one full block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:16] <= 8'd128)
		else $error("run count above block size");

endmodule

bind rgb565_rle_block_decoder_core rgbrle_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// RGB565 run-length decoder testbench
// Feeds begin and byte transfers through the core with random gaps on both
// streams and checks every result against an in-bench decoder model.
// ----------------------------------------------------------------------------
module testbench;
	import rgbrle_pkg::*;

	localparam int ClkHalf    = 2;
	localparam int CycleLimit = 300000;
	localparam int ItemGoal   = 940;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	rgb565_rle_block_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// stimulus waiting to be sent, and decoded results still owed by the core
	item_t   stream_items[$];
	result_t owed_results[$];
	item_t   item_on_bus;

	// decoder model state
	logic [CountW-1:0] bytes_seen;
	logic [CountW-1:0] frame_len;
	logic              rle_mode;
	logic [BlockW-1:0] blk_len;
	logic [BlockW-1:0] blk_pos;
	logic              blk_common;
	logic [7:0]        held_low;

	int cycles = 0;
	int items_sent = 0;
	int mismatches = 0;
	int pixel_hits = 0;
	int run_hits = 0;
	int reject_hits = 0;

	initial begin
		forever #ClkHalf clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Timeout after %0d cycles, %0d results still owed", cycles,
				owed_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	// random gaps, with one calm window where both streams run flat out
	function automatic bit take_break();
		if (cycles >= 200 && cycles < 600)
			return 1'b0;
		return $urandom_range(0, 99) < 31;
	endfunction

	function automatic logic [31:0] pack_item(item_t it);
		return {6'b0, it.data_byte, it.rle_enable, it.rect_height, it.rect_width};
	endfunction

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------
	task automatic pair_pixel_byte(input logic [7:0] b);
		bytes_seen = bytes_seen + 1'b1;
		if (bytes_seen[0])
			held_low = b;
		else
			owed_results.push_back('{pixel_color: {b, held_low}, run_count: 8'd1,
				rejected: 1'b0, rejected_byte: 8'd0});
	endtask

	task automatic decode_step(input item_t it);
		logic [8:0] w;
		logic [7:0] h;
		logic [7:0] b;
		b = it.data_byte;
		if (it.cmd == CmdBegin) begin
			w = (it.rect_width > MaxWidth) ? 9'(MaxWidth) : it.rect_width;
			h = (it.rect_height > MaxHeight) ? 8'(MaxHeight) : it.rect_height;
			frame_len  = CountW'(w * h * 2);
			bytes_seen = '0;
			rle_mode   = it.rle_enable;
			blk_len    = '0;
			blk_pos    = '0;
			blk_common = 1'b0;
		end else if (bytes_seen >= frame_len) begin
			owed_results.push_back('{pixel_color: 16'd0, run_count: 8'd0,
				rejected: 1'b1, rejected_byte: b});
		end else if (!rle_mode) begin
			pair_pixel_byte(b);
		end else if (blk_pos >= blk_len) begin
			// block header: low bits give the pixel count minus one, top bit marks a common block
			blk_len    = BlockW'(({2'b0, b[6:0]} + 9'd1) << 1);
			blk_common = b[7];
			blk_pos    = b[7] ? blk_len - 9'd2 : 9'd0;
		end else begin
			blk_pos = blk_pos + 1'b1;
			if (!blk_common) begin
				pair_pixel_byte(b);
			end else if (blk_pos >= blk_len) begin
				owed_results.push_back('{pixel_color: {b, held_low},
					run_count: 8'(blk_len >> 1), rejected: 1'b0, rejected_byte: 8'd0});
				bytes_seen = bytes_seen + CountW'(blk_len);
			end else begin
				held_low = b;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus builders; unused fields carry random values
	// ------------------------------------------------------------------------
	task automatic add_begin(input int w, input int h, input bit rle);
		item_t it;
		it.cmd         = CmdBegin;
		it.rect_width  = 9'(w);
		it.rect_height = 8'(h);
		it.rle_enable  = rle;
		it.data_byte   = 8'($urandom);
		stream_items.push_back(it);
	endtask

	task automatic add_byte(input logic [7:0] b);
		item_t it;
		it.cmd         = CmdData;
		it.rect_width  = 9'($urandom);
		it.rect_height = 8'($urandom);
		it.rle_enable  = 1'($urandom);
		it.data_byte   = b;
		stream_items.push_back(it);
	endtask

	// well-formed frame content, cut short after budget bytes
	task automatic add_frame(input int w, input int h, input bit rle, input int budget);
		int pix;
		int len;
		int k;
		bit common;
		pix = ((w > MaxWidth) ? MaxWidth : w) * ((h > MaxHeight) ? MaxHeight : h);
		add_begin(w, h, rle);
		while (pix > 0 && budget > 0) begin
			if (rle) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
					: $urandom_range(0, 5);
				common = $urandom_range(0, 1);
				add_byte({common, 7'(len)});
				budget--;
				for (k = 0; k < (common ? 2 : 2 * (len + 1)) && budget > 0; k++) begin
					add_byte(8'($urandom));
					budget--;
				end
				pix -= len + 1;
			end else begin
				for (k = 0; k < 2 && budget > 0; k++) begin
					add_byte(8'($urandom));
					budget--;
				end
				pix--;
			end
		end
		// trailing bytes, past the frame end unless the budget cut the frame short
		for (k = $urandom_range(0, 2); k > 0; k--)
			add_byte(8'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Driver: present queued items, update the model on each input transfer
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_step(item_on_bus);
				items_sent <= items_sent + 1;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (stream_items.size() > 0 && !take_break()) begin
					item_on_bus = stream_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pack_item(item_on_bus);
					s_axis_tuser  <= item_on_bus.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each output transfer with the oldest owed result
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.pixel_color   = m_axis_tdata[15:0];
				got.run_count     = m_axis_tdata[23:16];
				got.rejected      = m_axis_tuser;
				got.rejected_byte = m_axis_tdata[31:24];
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0d] result with nothing owed: ", cycles,
							"color %h run %0d rej %b byte %h",
							got.pixel_color, got.run_count, got.rejected,
							got.rejected_byte);
				end else begin
					want = owed_results.pop_front();
					if (got.pixel_color !== want.pixel_color || got.run_count !== want.run_count
							|| got.rejected !== want.rejected
							|| got.rejected_byte !== want.rejected_byte) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0d] mismatch: ", cycles,
								"want color %h run %0d rej %b byte %h, ",
								want.pixel_color, want.run_count, want.rejected,
								want.rejected_byte,
								"got color %h run %0d rej %b byte %h",
								got.pixel_color, got.run_count, got.rejected,
								got.rejected_byte);
					end
					if (want.rejected)
						reject_hits++;
					else if (want.run_count > 1)
						run_hits++;
					else
						pixel_hits++;
				end
			end
			m_axis_tready <= !take_break();
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: reset, directed cases, random frames, drain, verdict
	// ------------------------------------------------------------------------
	initial begin
		int roll;
		bytes_seen = '0;
		frame_len  = '0;
		rle_mode   = 1'b0;
		blk_len    = '0;
		blk_pos    = '0;
		blk_common = 1'b0;
		held_low   = '0;

		// bytes before any begin are handed back
		add_byte(8'h00);
		add_byte(8'hFF);
		// empty rectangle rejects everything
		add_begin(0, 5, 0);
		add_byte(8'hA5);
		// one raw pixel, then a byte past the frame end
		add_begin(1, 1, 0);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h12);
		// common block that fills the frame exactly
		add_begin(2, 1, 1);
		add_byte(8'h81);
		add_byte(8'h34);
		add_byte(8'h12);
		add_byte(8'h56);
		// longest common run overshoots a one-pixel frame
		add_begin(1, 1, 1);
		add_byte(8'hFF);
		add_byte(8'hCD);
		add_byte(8'hAB);
		add_byte(8'h00);
		// oversized rectangle saturates; begin lands inside a literal block
		add_begin(511, 255, 1);
		add_byte(8'h01);
		add_byte(8'h3C);
		add_byte(8'hC3);
		add_begin(1, 2, 0);
		add_byte(8'h11);
		add_byte(8'h22);

		// random frames: mostly small and well formed, some cut, some huge, some noise
		while (stream_items.size() < ItemGoal) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				add_frame($urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 1),
					1000);
			else if (roll < 82)
				add_frame($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 1),
					$urandom_range(1, 12));
			else if (roll < 88)
				add_frame($urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 1),
					$urandom_range(4, 14));
			else if ($urandom_range(0, 3) == 0)
				add_begin($urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 1));
			else
				add_byte(8'($urandom));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all items sent, all results back, then a short settle
		do @(negedge clk);
		while (stream_items.size() > 0 || s_axis_tvalid || owed_results.size() > 0);
		repeat (10) @(negedge clk);

		$display("Sent %0d items (begins and bytes, raw and run-length frames).", items_sent);
		$display("Checked %0d pixels, %0d common runs, %0d rejected bytes.",
			pixel_hits, run_hits, reject_hits);
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/rgbrle_pkg.sv
sv/rgbrle_dec.sv
sv/rgbrle_out.sv
sv/rgb565_rle_block_decoder_core.sv
sv/rgbrle_chk.sv
bench/testbench.sv
